// File: sv/acodl_pkg.sv
package acodl_pkg;

  localparam int CALIB_LOG2 = 8;
  localparam int SAMPLE_W   = 16;
  localparam int OFFSET_W   = 24;
  localparam int FILT_W     = 25;
  localparam int SUM_W      = 28;
  localparam int CNT_W      = 12;
  localparam int DB_W       = 23;
  localparam int ALPHA_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 23;

  localparam logic [CNT_W-1:0] CALIB_LAST = CNT_W'((1 << CALIB_LOG2) - 1);

  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA    = 2'd1;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd58982;

  typedef struct packed {
    logic signed [OFFSET_W-1:0] offset;
    logic                       done;
    logic                       calibrated;
  } calib_status_t;

endpackage

// File: sv/acodl_calib.sv
module acodl_calib (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       fire,
  input  logic                                       func,
  input  logic signed [acodl_pkg::SAMPLE_W-1:0]      sample,
  output acodl_pkg::calib_status_t                   status
);
  import acodl_pkg::*;

  logic signed [OFFSET_W-1:0] zero_offset_r;
  logic signed [SUM_W-1:0]    calib_sum_r;
  logic [CNT_W-1:0]           calib_count_r;
  logic                       is_calibrated_r;

  logic signed [SUM_W-1:0]    sum_nxt;
  logic signed [SUM_W+7:0]    scaled;
  logic                       last;

  assign sum_nxt = calib_sum_r + SUM_W'(sample);
  assign scaled  = {sum_nxt, 8'b0};
  assign last    = func && (calib_count_r >= CALIB_LAST);

  assign status.offset     = zero_offset_r;
  assign status.done       = last;
  assign status.calibrated = is_calibrated_r || last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_offset_r   <= '0;
      calib_sum_r     <= '0;
      calib_count_r   <= '0;
      is_calibrated_r <= 1'b0;
    end else if (fire && func) begin
      if (last) begin
        zero_offset_r   <= OFFSET_W'(scaled >>> CALIB_LOG2);
        calib_sum_r     <= '0;
        calib_count_r   <= '0;
        is_calibrated_r <= 1'b1;
      end else begin
        calib_sum_r   <= sum_nxt;
        calib_count_r <= calib_count_r + 1'b1;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    calib_count_r <= CALIB_LAST)
    else $error("calibration count past end of run");

  a_cal_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    is_calibrated_r |=> is_calibrated_r)
    else $error("calibrated flag dropped");

  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && last |=> calib_count_r == '0 && calib_sum_r == '0)
    else $error("run state not cleared after completion");

endmodule

// File: sv/acodl_filter.sv
module acodl_filter (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   fire,
  input  logic                                   func,
  input  logic signed [acodl_pkg::SAMPLE_W-1:0]  sample,
  input  acodl_pkg::calib_status_t               cal,
  input  logic [acodl_pkg::DB_W-1:0]             deadband,
  input  logic [acodl_pkg::ALPHA_W-1:0]          alpha,
  output logic signed [acodl_pkg::FILT_W-1:0]    smoothed_nxt
);
  import acodl_pkg::*;

  logic signed [FILT_W-1:0]   smoothed_r;
  logic signed [FILT_W:0]     d_full;
  logic [FILT_W:0]            mag;
  logic signed [FILT_W:0]     d_db;
  logic signed [FILT_W+1:0]   diff;
  logic [ALPHA_W:0]           weight;
  logic signed [FILT_W+19:0]  prod;
  logic signed [FILT_W+1:0]   filt_sum;

  assign d_full   = (FILT_W+1)'($signed({sample, 8'b0})) - (FILT_W+1)'($signed(cal.offset));
  assign mag      = d_full[FILT_W] ? (FILT_W+1)'(-d_full) : d_full;
  assign d_db     = (mag < (FILT_W+1)'(deadband)) ? '0 : d_full;
  assign diff     = (FILT_W+2)'(d_db) - (FILT_W+2)'(smoothed_r);
  assign weight   = 17'h10000 - {1'b0, alpha};
  assign prod     = diff * $signed({1'b0, weight});
  assign filt_sum = (FILT_W+2)'(smoothed_r) + (FILT_W+2)'(prod >>> 16);

  always_comb begin
    if (!func) begin
      smoothed_nxt = filt_sum[FILT_W-1:0];
    end else if (cal.done) begin
      smoothed_nxt = '0;
    end else begin
      smoothed_nxt = smoothed_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smoothed_r <= '0;
    end else if (fire) begin
      smoothed_r <= smoothed_nxt;
    end
  end

  a_calib_holds: assert property (@(posedge clk) disable iff (!rst_n)
    fire && func && !cal.done |=> $stable(smoothed_r))
    else $error("filter state moved on calibration sample");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !func |-> filt_sum[FILT_W+1] == filt_sum[FILT_W]
                   && filt_sum[FILT_W] == filt_sum[FILT_W-1])
    else $error("filter result out of range");

  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    fire && cal.done |=> smoothed_r == '0)
    else $error("filter state not cleared on calibration");

endmodule

// File: sv/accel_offset_deadband_lowpass_core.sv
// Accelerometer zero-offset calibration, dead zone and first-order low-pass.
// Every accepted sample yields exactly one result. One item per clock is
// sustained while the output is not stalled: a sample sits in the input
// register, passes the offset subtract, dead-zone test and the single 17x27
// multiply-add of the filter combinationally, and lands in the output
// register; the filter state is fed back within that same cycle. The result
// turns valid in the output register, loaded from the input register.
// Calibration samples are summed; after 2^CALIB_LOG2 of them the mean
// becomes the offset, the filter clears and calibrated rises. Write deadband
// (index 0) and alpha (index 1) only while idle.
module accel_offset_deadband_lowpass_core (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic                                    in_func,
  input  logic signed [acodl_pkg::SAMPLE_W-1:0]   in_sample,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [acodl_pkg::FILT_W-1:0]     out_filtered,
  output logic                                    out_calibrated,
  output logic                                    out_calib_done,
  input  logic                                    cfg_wr_en,
  input  logic [acodl_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [acodl_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
  import acodl_pkg::*;

  logic [DB_W-1:0]           deadband_r;
  logic [ALPHA_W-1:0]        alpha_r;
  logic                      s1_valid_r;
  logic                      s1_func_r;
  logic signed [SAMPLE_W-1:0] s1_sample_r;
  logic                      out_valid_r;
  logic signed [FILT_W-1:0]  out_filtered_r;
  logic                      out_calibrated_r;
  logic                      out_calib_done_r;
  logic                      advance;
  calib_status_t             cal;
  logic signed [FILT_W-1:0]  smoothed_nxt;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  assign out_valid      = out_valid_r;
  assign out_filtered   = out_filtered_r;
  assign out_calibrated = out_calibrated_r;
  assign out_calib_done = out_calib_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadband_r <= '0;
      alpha_r    <= ALPHA_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_DEADBAND: deadband_r <= cfg_wdata[DB_W-1:0];
        REG_ALPHA:    alpha_r    <= cfg_wdata[ALPHA_W-1:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_func_r   <= in_func;
      s1_sample_r <= in_sample;
    end
  end

  acodl_calib u_calib (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (advance),
    .func   (s1_func_r),
    .sample (s1_sample_r),
    .status (cal)
  );

  acodl_filter u_filter (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (advance),
    .func         (s1_func_r),
    .sample       (s1_sample_r),
    .cal          (cal),
    .deadband     (deadband_r),
    .alpha        (alpha_r),
    .smoothed_nxt (smoothed_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_filtered_r   <= smoothed_nxt;
      out_calibrated_r <= cal.calibrated;
      out_calib_done_r <= cal.done;
    end
  end

  a_done_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_calib_done_r |-> out_calibrated_r && out_filtered_r == '0)
    else $error("completion result inconsistent");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_ready)
    else $error("input stalled with empty stage");

  a_advance_loads: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("result lost after transfer");

endmodule

// File: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import acodl_pkg::*;

  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_CALIB  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam int DRAIN_CYCLES   = 4;
  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int N_PHASES       = 7;
  localparam int PHASE_ITEMS    = 250;
  localparam int N_ROWS         = 27;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

  typedef struct packed {
    logic signed [FILT_W-1:0] filtered;
    logic                     calibrated;
    logic                     calib_done;
  } accel_res_t;

  typedef struct packed {
    row_kind_t                  kind;
    logic                       func;
    logic signed [SAMPLE_W-1:0] sample;
    logic [CFG_IDX_W-1:0]       reg_idx;
    logic [CFG_DATA_W-1:0]      wdata;
    logic                       typed;
    accel_res_t                 want;
  } stim_row_t;

  localparam accel_res_t NO_WANT = '0;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic                         in_func = OP_FILTER;
  logic signed [SAMPLE_W-1:0]   in_sample = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic signed [FILT_W-1:0]     out_filtered;
  logic                         out_calibrated;
  logic                         out_calib_done;
  logic                         cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]         cfg_index = '0;
  logic [CFG_DATA_W-1:0]        cfg_wdata = '0;

  // predictor state
  logic signed [OFFSET_W-1:0]   p_offset = '0;
  logic signed [FILT_W-1:0]     p_smooth = '0;
  logic signed [SUM_W-1:0]      p_sum = '0;
  logic [CNT_W-1:0]             p_count = '0;
  logic                         p_cal = 1'b0;
  logic [DB_W-1:0]              p_deadband = '0;
  logic [ALPHA_W-1:0]           p_alpha = ALPHA_RESET;

  accel_res_t filter_results_q [$];
  int         n_mismatch = 0;
  int         pending_gap = 1;
  bit         tx_burst = 1'b0;
  bit         hold_off_req = 1'b0;
  int         idle_cycles = 0;

  stim_row_t dir_rows [N_ROWS] = '{
    '{ROW_ITEM,  OP_FILTER, 16'sd0,     REG_DEADBAND, 23'd0, 1'b1, '{25'sd0, 1'b0, 1'b0}},
    '{ROW_ITEM,  OP_FILTER, 16'sh7FFF,  REG_DEADBAND, 23'd0, 1'b0, NO_WANT},
    '{ROW_ITEM,  OP_FILTER, 16'sh8000,  REG_DEADBAND, 23'd0, 1'b0, NO_WANT},
    '{ROW_ITEM,  OP_CALIB,  16'sh8000,  REG_DEADBAND, 23'd0, 1'b0, NO_WANT},
    '{ROW_ITEM,  OP_CALIB,  16'sh7FFF,  REG_DEADBAND, 23'd0, 1'b0, NO_WANT},
    '{ROW_WRITE, OP_FILTER, 16'sd0,     REG_ALPHA,    23'd0, 1'b0, NO_WANT},
    '{ROW_WRITE, OP_FILTER, 16'sd0,     REG_DEADBAND, 23'd0, 1'b0, NO_WANT},
    '{ROW_ITEM,  OP_FILTER, 16'sh7FFF,  REG_DEADBAND, 23'd0, 1'b1,
      '{25'sd8388352, 1'b0, 1'b0}},
    '{ROW_ITEM,  OP_FILTER, 16'sh8000,  REG_DEADBAND, 23'd0, 1'b1,
      '{-25'sd8388608, 1'b0, 1'b0}},
    '{ROW_ITEM,  OP_FILTER, 16'shFFFF,  REG_DEADBAND, 23'd0, 1'b1, '{-25'sd256, 1'b0, 1'b0}},
    '{ROW_ITEM,  OP_FILTER, 16'sd1,     REG_DEADBAND, 23'd0, 1'b1, '{25'sd256, 1'b0, 1'b0}},
    '{ROW_ITEM,  OP_CALIB,  16'sd100,   REG_DEADBAND, 23'd0, 1'b1, '{25'sd256, 1'b0, 1'b0}},
    '{ROW_WRITE, OP_FILTER, 16'sd0,     REG_DEADBAND, 23'd512, 1'b0, NO_WANT},
    '{ROW_ITEM,  OP_FILTER, 16'sd1,     REG_DEADBAND, 23'd0, 1'b1, '{25'sd0, 1'b0, 1'b0}},
    '{ROW_ITEM,  OP_FILTER, 16'sd2,     REG_DEADBAND, 23'd0, 1'b1, '{25'sd512, 1'b0, 1'b0}},
    '{ROW_ITEM,  OP_FILTER, 16'shFFFE,  REG_DEADBAND, 23'd0, 1'b1, '{-25'sd512, 1'b0, 1'b0}},
    '{ROW_ITEM,  OP_FILTER, 16'shFFFF,  REG_DEADBAND, 23'd0, 1'b1, '{25'sd0, 1'b0, 1'b0}},
    '{ROW_WRITE, OP_FILTER, 16'sd0,     REG_DEADBAND, 23'h7FFFFF, 1'b0, NO_WANT},
    '{ROW_ITEM,  OP_FILTER, 16'sh7FFF,  REG_DEADBAND, 23'd0, 1'b1, '{25'sd0, 1'b0, 1'b0}},
    '{ROW_ITEM,  OP_FILTER, 16'sh8000,  REG_DEADBAND, 23'd0, 1'b1,
      '{-25'sd8388608, 1'b0, 1'b0}},
    '{ROW_WRITE, OP_FILTER, 16'sd0,     REG_SPARE_A,  23'h7FFFFF, 1'b0, NO_WANT},
    '{ROW_WRITE, OP_FILTER, 16'sd0,     REG_SPARE_B,  23'h2AAAAA, 1'b0, NO_WANT},
    '{ROW_WRITE, OP_FILTER, 16'sd0,     REG_ALPHA,    23'h00FFFF, 1'b0, NO_WANT},
    '{ROW_ITEM,  OP_FILTER, 16'sh8000,  REG_DEADBAND, 23'd0, 1'b0, NO_WANT},
    '{ROW_ITEM,  OP_FILTER, 16'sh5555,  REG_DEADBAND, 23'd0, 1'b0, NO_WANT},
    '{ROW_ITEM,  OP_CALIB,  16'shAAAA,  REG_DEADBAND, 23'd0, 1'b0, NO_WANT},
    '{ROW_ITEM,  OP_FILTER, 16'sd0,     REG_DEADBAND, 23'd0, 1'b0, NO_WANT}
  };

  accel_offset_deadband_lowpass_core u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_sample      (in_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_filtered   (out_filtered),
    .out_calibrated (out_calibrated),
    .out_calib_done (out_calib_done),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic accel_res_t accel_step(input logic f,
                                            input logic signed [SAMPLE_W-1:0] s);
    accel_res_t r;
    longint     d;
    longint     acc;
    r.calib_done = 1'b0;
    if (f == OP_CALIB) begin
      p_sum = p_sum + s;
      if (p_count >= CALIB_LAST) begin
        p_offset = OFFSET_W'((longint'(p_sum) * 256) >>> CALIB_LOG2);
        p_smooth = '0;
        p_cal = 1'b1;
        p_sum = '0;
        p_count = '0;
        r.calib_done = 1'b1;
      end else begin
        p_count = p_count + 1'b1;
      end
    end else begin
      d = longint'(s) * 256 - longint'(p_offset);
      if ((d < 0 ? -d : d) < longint'(p_deadband)) d = 0;
      acc = longint'(p_alpha) * longint'(p_smooth) + (64'sd65536 - longint'(p_alpha)) * d;
      p_smooth = FILT_W'(acc >>> 16);
    end
    r.filtered = p_smooth;
    r.calibrated = p_cal;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    n_mismatch++;
    if (n_mismatch <= 50)
      $display("tb: mismatch on %s at %0t: got %0d, want %0d", what, $realtime, got, want);
  endtask

  // drop valid, let every result come back, then let the pipeline settle
  task automatic wait_idle();
    if (pending_gap == 0) in_valid <= 1'b0;
    pending_gap = 1;
    while (filter_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_DEADBAND: p_deadband = val;
      REG_ALPHA:    p_alpha = val[ALPHA_W-1:0];
      default: ;
    endcase
  endtask

  // valid stays high into the next call when the next gap is zero
  task automatic send_item(input logic f, input logic signed [SAMPLE_W-1:0] s,
                           input logic typed, input accel_res_t want);
    accel_res_t pred;
    if (pending_gap > 0) repeat (pending_gap) @(posedge clk);
    in_valid <= 1'b1;
    in_func <= f;
    in_sample <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = accel_step(f, s);
    filter_results_q.push_back(typed ? want : pred);
    if ($urandom_range(0, 29) == 0) tx_burst = !tx_burst;
    pending_gap = tx_burst ? 0 : $urandom_range(0, 10);
    if (pending_gap > 0) in_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: no transfer for %0d cycles", idle_cycles);
      $display("tb: errors");
      $finish;
    end
  end

  initial begin : result_side
    int         stall;
    bit         rx_busy;
    accel_res_t exp_res;
    rx_busy = 1'b1;
    wait (rst_n);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_busy = !rx_busy;
      stall = rx_busy ? $urandom_range(0, 10) : 0;
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (filter_results_q.size() == 0) begin
        report_mismatch("unexpected transfer, filtered", longint'(out_filtered), 0);
      end else begin
        exp_res = filter_results_q.pop_front();
        if (out_filtered !== exp_res.filtered)
          report_mismatch("filtered", longint'(out_filtered), longint'(exp_res.filtered));
        if (out_calibrated !== exp_res.calibrated)
          report_mismatch("calibrated", out_calibrated, exp_res.calibrated);
        if (out_calib_done !== exp_res.calib_done)
          report_mismatch("calib_done", out_calib_done, exp_res.calib_done);
      end
    end
  end

  initial begin : sample_side
    logic                       f;
    logic signed [SAMPLE_W-1:0] s;
    logic signed [SAMPLE_W-1:0] level;
    logic [DB_W-1:0]            db;
    logic [ALPHA_W-1:0]         al;
    int                         cal_left;
    int                         spread;
    cal_left = 0;
    spread = 8;
    level = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE)
        write_reg(dir_rows[i].reg_idx, dir_rows[i].wdata);
      else
        send_item(dir_rows[i].func, dir_rows[i].sample, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin db = '0; al = ALPHA_RESET; end
        1: begin db = '1; al = '1; end
        2: begin db = DB_W'($urandom_range(0, 4096)); al = ALPHA_W'($urandom); end
        3: begin db = '0; al = '0; end
        4: begin db = DB_W'($urandom); al = ALPHA_W'($urandom); end
        5: begin db = DB_W'($urandom_range(0, 2048)); al = '1; end
        default: begin db = DB_W'($urandom); al = ALPHA_W'($urandom_range(60000, 65535)); end
      endcase
      write_reg(REG_DEADBAND, db);
      write_reg(REG_ALPHA, CFG_DATA_W'(al));
      if (ph == N_PHASES - 1) begin
        write_reg(REG_SPARE_A, CFG_DATA_W'($urandom));
        write_reg(REG_SPARE_B, CFG_DATA_W'($urandom));
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 2 && k == 40) hold_off_req = 1'b1;
        if (ph == 4 && k == 120) wait_idle();
        if (cal_left == 0 && $urandom_range(0, 99) == 0) begin
          cal_left = 1 << CALIB_LOG2;
          level = SAMPLE_W'($urandom);
          case ($urandom_range(0, 2))
            0: spread = 8;
            1: spread = 200;
            default: spread = 4000;
          endcase
        end
        if (cal_left > 0 && $urandom_range(0, 99) < 60) begin
          f = OP_CALIB;
          cal_left--;
          s = SAMPLE_W'(int'(level) + int'($urandom_range(0, 2 * spread)) - spread);
        end else if (cal_left == 0 && $urandom_range(0, 99) < 3) begin
          f = OP_CALIB;
          s = SAMPLE_W'($urandom);
        end else begin
          f = OP_FILTER;
          if ($urandom_range(0, 99) < 70)
            s = SAMPLE_W'(int'(level) + int'($urandom_range(0, 2 * spread)) - spread);
          else
            s = SAMPLE_W'($urandom);
        end
        send_item(f, s, 1'b0, NO_WANT);
      end
    end

    wait_idle();
    if (n_mismatch == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
